// File: rtl/core/bitmap_line_pixel_stepper_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap line pixel stepper
// Shared concurrent check forms; they expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef BITMAP_LINE_PIXEL_STEPPER_ASSERT_SVH
`define BITMAP_LINE_PIXEL_STEPPER_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define BLPS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("blps: same-cycle check failed");

// Next-cycle implication, switched off while reset is held.
`define BLPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("blps: next-cycle check failed");

`endif

// File: rtl/core/blps_pkg.sv
// ----------------------------------------------------------------------------
// blps_pkg
// Types, function codes and address constants of the line pixel stepper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package blps_pkg;

  localparam int COORD_W = 8;
  localparam int ERR_W   = 9;
  localparam int ADDR_W  = 16;

  // Function codes of an input transaction.
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  // Character-cell bitmap layout.
  localparam logic [COORD_W-1:0] COL_MASK   = 8'hF8;
  localparam logic [COORD_W-1:0] ROW_MASK   = 8'h07;
  localparam logic [COORD_W-1:0] MASK_TOP   = 8'h80;
  localparam logic [ADDR_W-1:0]  ROW_STRIDE = 16'd320;

  // One pixel position handed from the stepper to the address stage.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               done;
  } pix_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: rtl/core/blps_channels.sv
// ----------------------------------------------------------------------------
// blps channel interfaces
// Valid/ready channels for the input commands and the pixel results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface blps_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [blps_pkg::COORD_W-1:0] start_x;
  logic [blps_pkg::COORD_W-1:0] end_x;
  logic [blps_pkg::COORD_W-1:0] start_y;
  logic [blps_pkg::COORD_W-1:0] end_y;

  modport source (output valid, func, start_x, end_x, start_y, end_y, input ready);
  modport sink   (input valid, func, start_x, end_x, start_y, end_y, output ready);
endinterface

interface blps_out_if;
  logic                         valid;
  logic                         ready;
  logic [blps_pkg::ADDR_W-1:0]  pixel_address;
  logic [blps_pkg::COORD_W-1:0] pixel_mask;
  logic                         line_done;

  modport source (output valid, pixel_address, pixel_mask, line_done, input ready);
  modport sink   (input valid, pixel_address, pixel_mask, line_done, output ready);
endinterface

// File: rtl/core/blps_front.sv
// ----------------------------------------------------------------------------
// blps_front
// Accepts commands, sets up lines and runs the Bresenham step per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "bitmap_line_pixel_stepper_assert.svh"

module blps_front (
  input  logic              clk,
  input  logic              rst_n,
  blps_in_if.sink           in_ch,
  input  blps_pkg::q_stat_t q_stat,
  output logic              push,
  output blps_pkg::pix_t    pix
);

  localparam int CW = blps_pkg::COORD_W;
  localparam int EW = blps_pkg::ERR_W;

  logic [CW-1:0] cur_x_r, cur_x_nxt;
  logic [CW-1:0] cur_y_r, cur_y_nxt;
  logic [CW-1:0] major_end_r, major_end_nxt;
  logic [CW-1:0] major_delta_r, major_delta_nxt;
  logic [CW-1:0] minor_delta_r, minor_delta_nxt;
  logic [EW-1:0] error_acc_r, error_acc_nxt;
  logic          y_is_major_r, y_is_major_nxt;
  logic          minor_dec_r, minor_dec_nxt;
  logic          line_active_r, line_active_nxt;

  logic          accept;
  logic          x_up, y_up, s_y_major;
  logic [CW-1:0] xd, yd;
  logic [CW-1:0] s_x, s_y, s_end, s_mdelta, s_ndelta;
  logic [EW-1:0] err_sum, err_new;
  logic          move_minor;
  logic [CW-1:0] a_x, a_y, a_major;

  // A transaction is taken whenever the queue has room.
  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;

  // Line set-up: extents, major axis and the endpoint drawn from.
  always_comb begin
    x_up      = in_ch.start_x < in_ch.end_x;
    y_up      = in_ch.start_y < in_ch.end_y;
    xd        = x_up ? (in_ch.end_x - in_ch.start_x) : (in_ch.start_x - in_ch.end_x);
    yd        = y_up ? (in_ch.end_y - in_ch.start_y) : (in_ch.start_y - in_ch.end_y);
    s_y_major = !(yd < xd);
    if (!s_y_major) begin
      s_mdelta = xd;
      s_ndelta = yd;
      s_x      = x_up ? in_ch.start_x : in_ch.end_x;
      s_y      = x_up ? in_ch.start_y : in_ch.end_y;
      s_end    = x_up ? in_ch.end_x : in_ch.start_x;
    end else begin
      s_mdelta = yd;
      s_ndelta = xd;
      s_x      = y_up ? in_ch.start_x : in_ch.end_x;
      s_y      = y_up ? in_ch.start_y : in_ch.end_y;
      s_end    = y_up ? in_ch.end_y : in_ch.start_y;
    end
  end

  // One Bresenham step from the held state.
  always_comb begin
    err_sum    = error_acc_r + {1'b0, minor_delta_r};
    move_minor = {1'b0, major_delta_r} < err_sum;
    err_new    = move_minor ? (err_sum - {1'b0, major_delta_r}) : err_sum;
    a_x        = cur_x_r;
    a_y        = cur_y_r;
    if (y_is_major_r) begin
      a_y = cur_y_r + CW'(1);
      if (move_minor) begin
        a_x = minor_dec_r ? (cur_x_r - CW'(1)) : (cur_x_r + CW'(1));
      end
    end else begin
      a_x = cur_x_r + CW'(1);
      if (move_minor) begin
        a_y = minor_dec_r ? (cur_y_r - CW'(1)) : (cur_y_r + CW'(1));
      end
    end
    a_major = y_is_major_r ? a_y : a_x;
  end

  // Next state and the pixel pushed into the queue.
  always_comb begin
    cur_x_nxt       = cur_x_r;
    cur_y_nxt       = cur_y_r;
    major_end_nxt   = major_end_r;
    major_delta_nxt = major_delta_r;
    minor_delta_nxt = minor_delta_r;
    error_acc_nxt   = error_acc_r;
    y_is_major_nxt  = y_is_major_r;
    minor_dec_nxt   = minor_dec_r;
    line_active_nxt = line_active_r;
    push            = 1'b0;
    pix             = '0;
    if (accept) begin
      if (in_ch.func == blps_pkg::FUNC_START) begin
        cur_x_nxt       = s_x;
        cur_y_nxt       = s_y;
        major_end_nxt   = s_end;
        major_delta_nxt = s_mdelta;
        minor_delta_nxt = s_ndelta;
        error_acc_nxt   = {2'b00, s_ndelta[CW-1:1]};
        y_is_major_nxt  = s_y_major;
        minor_dec_nxt   = x_up != y_up;
        push            = 1'b1;
        pix.x           = s_x;
        pix.y           = s_y;
        pix.done        = (s_y_major ? s_y : s_x) == s_end;
        line_active_nxt = !pix.done;
      end else if (line_active_r) begin
        cur_x_nxt       = a_x;
        cur_y_nxt       = a_y;
        error_acc_nxt   = err_new;
        push            = 1'b1;
        pix.x           = a_x;
        pix.y           = a_y;
        pix.done        = a_major == major_end_r;
        line_active_nxt = !pix.done;
      end
    end
  end

  // State registers; line_active is the only control bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r       <= '0;
      cur_y_r       <= '0;
      major_end_r   <= '0;
      major_delta_r <= '0;
      minor_delta_r <= '0;
      error_acc_r   <= '0;
      y_is_major_r  <= 1'b0;
      minor_dec_r   <= 1'b0;
      line_active_r <= 1'b0;
    end else begin
      cur_x_r       <= cur_x_nxt;
      cur_y_r       <= cur_y_nxt;
      major_end_r   <= major_end_nxt;
      major_delta_r <= major_delta_nxt;
      minor_delta_r <= minor_delta_nxt;
      error_acc_r   <= error_acc_nxt;
      y_is_major_r  <= y_is_major_nxt;
      minor_dec_r   <= minor_dec_nxt;
      line_active_r <= line_active_nxt;
    end
  end

  // A step with no line in progress produces nothing.
  `BLPS_ASSERT_IMP(a_idle_step_silent,
                   accept && in_ch.func == blps_pkg::FUNC_STEP && !line_active_r, !push)
  // The last pixel of a line closes it.
  `BLPS_ASSERT_NEXT(a_done_closes_line, push && pix.done, !line_active_r)

endmodule

// File: rtl/core/blps_queue.sv
// ----------------------------------------------------------------------------
// blps_queue
// Short pixel queue between the stepper and the address stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "bitmap_line_pixel_stepper_assert.svh"

module blps_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  blps_pkg::pix_t     wr_pix,
  input  logic               pop,
  output blps_pkg::pix_t     rd_pix,
  output blps_pkg::q_stat_t  q_stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  blps_pkg::pix_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign q_stat.full  = count_r == CNT_W'(DEPTH);
  assign q_stat.empty = count_r == '0;
  assign rd_pix       = mem[rd_ptr_r];

  // Pointer and fill count update; the writer never pushes when full.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_pix;
    end
  end

  // The fill count stays within the queue depth.
  `BLPS_ASSERT_IMP(a_q_count_bound, 1'b1, count_r <= CNT_W'(DEPTH))

endmodule

// File: rtl/core/blps_back.sv
// ----------------------------------------------------------------------------
// blps_back
// Forms byte address and mask of each pixel and holds the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "bitmap_line_pixel_stepper_assert.svh"

module blps_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [blps_pkg::COORD_W-1:0] cfg_wdata,
  input  blps_pkg::pix_t               rd_pix,
  input  blps_pkg::q_stat_t            q_stat,
  output logic                         pop,
  blps_out_if.source                   out_ch
);

  localparam int CW = blps_pkg::COORD_W;
  localparam int AW = blps_pkg::ADDR_W;

  logic [CW-1:0] bitmap_page_r;
  logic          out_valid_r, out_valid_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [CW-1:0] mask_r, mask_nxt;
  logic          done_r;
  logic          load;

  // Bitmap page register; to be written only while the block is idle, which it does not enforce.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bitmap_page_r <= '0;
    end else if (cfg_we) begin
      bitmap_page_r <= cfg_wdata;
    end
  end

  // The output register takes a new pixel when empty or being drained.
  assign load = !out_valid_r || out_ch.ready;
  assign pop  = load && !q_stat.empty;

  // Address is page base plus cell column, cell row times row stride, and line in cell.
  always_comb begin
    addr_nxt = {bitmap_page_r, {CW{1'b0}}}
             + AW'(rd_pix.x & blps_pkg::COL_MASK)
             + AW'(rd_pix.y[CW-1:3]) * blps_pkg::ROW_STRIDE
             + AW'(rd_pix.y & blps_pkg::ROW_MASK);
    mask_nxt = blps_pkg::MASK_TOP >> rd_pix.x[2:0];
    out_valid_nxt = load ? !q_stat.empty : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      addr_r <= addr_nxt;
      mask_r <= mask_nxt;
      done_r <= rd_pix.done;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pixel_address = addr_r;
  assign out_ch.pixel_mask    = mask_r;
  assign out_ch.line_done     = done_r;

  // Every presented mask selects exactly one pixel of the byte.
  `BLPS_ASSERT_IMP(a_mask_onehot, out_valid_r, $onehot(mask_r))

endmodule

// File: rtl/core/bitmap_line_pixel_stepper.sv
// ----------------------------------------------------------------------------
// bitmap_line_pixel_stepper
// Bresenham line rasteriser giving byte address and mask for each pixel of a
// character-cell hires bitmap. A start transaction (func 0) loads both
// endpoints and yields the first pixel; each step transaction (func 1) yields
// the next pixel until the one flagged line_done, and a step with no line in
// progress yields nothing. One transaction is taken every clock cycle while
// results drain. A result is registered in the queue entry that the stepper
// writes, the stepper's error-term add and compare being combinational, and
// then in the address stage's output register before it is presented. The
// short queue between the two absorbs output stalls. Write bitmap_page
// through cfg_we and cfg_wdata only while no transaction is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bitmap_line_pixel_stepper #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [blps_pkg::COORD_W-1:0] cfg_wdata,
  blps_in_if.sink                      in_ch,
  blps_out_if.source                   out_ch
);

  blps_pkg::pix_t    push_pix;
  blps_pkg::pix_t    head_pix;
  blps_pkg::q_stat_t q_stat;
  logic              push;
  logic              pop;

  // Front: command intake, line set-up and stepping.
  blps_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .push   (push),
    .pix    (push_pix)
  );

  // Queue of pixel positions between the two sides.
  blps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_pix (push_pix),
    .pop    (pop),
    .rd_pix (head_pix),
    .q_stat (q_stat)
  );

  // Back: address and mask formation, result register.
  blps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rd_pix    (head_pix),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

// File: sim/tb_bitmap_line_pixel_stepper.sv
// ----------------------------------------------------------------------------
// tb_bitmap_line_pixel_stepper
// Self-checking testbench for the line pixel stepper. Start and step commands
// are driven through the input channel with random gaps. A Bresenham line
// tracker in the bench predicts the byte address, mask and end flag of every
// pixel. Each pixel on the output channel, taken under random back-pressure,
// is checked against the oldest prediction. The bitmap page is changed
// between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bitmap_line_pixel_stepper;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned ITEMS_PER_PHASE = 230;
  localparam int unsigned PHASES = 6;
  localparam int CW = blps_pkg::COORD_W;
  localparam int EW = blps_pkg::ERR_W;
  localparam int AW = blps_pkg::ADDR_W;

  // One command as presented on the input channel.
  typedef struct packed {
    logic          func;
    logic [CW-1:0] x0;
    logic [CW-1:0] x1;
    logic [CW-1:0] y0;
    logic [CW-1:0] y1;
  } line_cmd_t;

  // One pixel write as seen on the output channel.
  typedef struct packed {
    logic [AW-1:0] addr;
    logic [CW-1:0] mask;
    logic          done;
  } pixel_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CW-1:0] cfg_wdata;

  blps_in_if  in_ch ();
  blps_out_if out_ch ();

  bitmap_line_pixel_stepper u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Commands waiting to be sent and pixels waiting to arrive.
  line_cmd_t pending_cmds[$];
  pixel_t    pending_pixels[$];

  // Line tracker state, mirroring the block after reset.
  logic [CW-1:0] page_shadow = '0;
  logic [CW-1:0] trk_x = '0;
  logic [CW-1:0] trk_y = '0;
  logic [CW-1:0] trk_major_end = '0;
  logic [CW-1:0] trk_major_delta = '0;
  logic [CW-1:0] trk_minor_delta = '0;
  logic [EW-1:0] trk_err = '0;
  logic          trk_y_major = 1'b0;
  logic          trk_minor_down = 1'b0;
  logic          trk_active = 1'b0;

  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  logic        cmd_taken = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  bit          send_burst = 1'b0;
  bit          recv_burst = 1'b0;

  // Clock generation: 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Gap lengths: mostly none or short, now and then long; none in bursts.
  function automatic int unsigned pick_gap(bit burst);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst) return 0;
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Address and mask of the pixel the tracker stands on; ends the line if last.
  task automatic emit_pixel();
    pixel_t px;
    logic [CW-1:0] major;
    px.addr = {page_shadow, 8'h00} + AW'(trk_x & blps_pkg::COL_MASK)
            + AW'(trk_y[7:3]) * blps_pkg::ROW_STRIDE
            + AW'(trk_y & blps_pkg::ROW_MASK);
    px.mask = blps_pkg::MASK_TOP >> trk_x[2:0];
    major = trk_y_major ? trk_y : trk_x;
    px.done = (major == trk_major_end);
    trk_active = !px.done;
    pending_pixels.push_back(px);
  endtask

  // Predict the pixel, if any, caused by one accepted command.
  task automatic rasterise(line_cmd_t cmd);
    logic x_up;
    logic y_up;
    logic [CW-1:0] xd;
    logic [CW-1:0] yd;
    logic move_minor;
    if (cmd.func == blps_pkg::FUNC_START) begin
      x_up = cmd.x0 < cmd.x1;
      y_up = cmd.y0 < cmd.y1;
      xd = x_up ? cmd.x1 - cmd.x0 : cmd.x0 - cmd.x1;
      yd = y_up ? cmd.y1 - cmd.y0 : cmd.y0 - cmd.y1;
      trk_y_major = !(yd < xd);
      trk_minor_down = (x_up != y_up);
      // Always draw from the end with the smaller major coordinate.
      if (!trk_y_major) begin
        trk_major_delta = xd;
        trk_minor_delta = yd;
        trk_x = x_up ? cmd.x0 : cmd.x1;
        trk_y = x_up ? cmd.y0 : cmd.y1;
        trk_major_end = x_up ? cmd.x1 : cmd.x0;
      end else begin
        trk_major_delta = yd;
        trk_minor_delta = xd;
        trk_y = y_up ? cmd.y0 : cmd.y1;
        trk_x = y_up ? cmd.x0 : cmd.x1;
        trk_major_end = y_up ? cmd.y1 : cmd.y0;
      end
      trk_err = EW'(trk_minor_delta >> 1);
      emit_pixel();
    end else if (trk_active) begin
      // One Bresenham step along the major axis.
      trk_err = trk_err + EW'(trk_minor_delta);
      move_minor = EW'(trk_major_delta) < trk_err;
      if (move_minor) trk_err = trk_err - EW'(trk_major_delta);
      if (trk_y_major) begin
        trk_y = trk_y + CW'(1);
        if (move_minor) trk_x = trk_minor_down ? trk_x - CW'(1) : trk_x + CW'(1);
      end else begin
        trk_x = trk_x + CW'(1);
        if (move_minor) trk_y = trk_minor_down ? trk_y - CW'(1) : trk_y + CW'(1);
      end
      emit_pixel();
    end
  endtask

  // Input side: count cycles, take accepted commands and predict their pixels.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    cmd_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      rasterise(pending_cmds.pop_front());
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bitmap_line_pixel_stepper verification failed");
      $finish;
    end
  end

  // Driver: present the next command at the falling edge, with random gaps.
  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) send_burst <= !send_burst;
    if (!in_ch.valid || cmd_taken) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        in_ch.valid   <= 1'b1;
        in_ch.func    <= pending_cmds[0].func;
        in_ch.start_x <= pending_cmds[0].x0;
        in_ch.end_x   <= pending_cmds[0].x1;
        in_ch.start_y <= pending_cmds[0].y0;
        in_ch.end_y   <= pending_cmds[0].y1;
        send_gap <= pick_gap(send_burst);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure, changed at the falling edge.
  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) recv_burst <= !recv_burst;
    if (recv_stall > 0) begin
      recv_stall <= recv_stall - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      recv_stall <= pick_gap(recv_burst);
    end
  end

  // Monitor: check each pixel transaction against the oldest prediction.
  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{addr: out_ch.pixel_address, mask: out_ch.pixel_mask,
              done: out_ch.line_done};
      if (pending_pixels.size() == 0) begin
        errors <= errors + 1;
        if (errors < MAX_REPORTS)
          $display("%0t: unexpected pixel addr %h mask %h done %b",
                   $realtime, got.addr, got.mask, got.done);
      end else begin
        want = pending_pixels.pop_front();
        if (got !== want) begin
          errors <= errors + 1;
          if (errors < MAX_REPORTS)
            $display("%0t: mismatch, want addr %h mask %h done %b, got %h %h %b",
                     $realtime, want.addr, want.mask, want.done,
                     got.addr, got.mask, got.done);
        end
      end
    end
  end

  task automatic push_cmd(logic func, logic [7:0] x0, logic [7:0] x1,
                          logic [7:0] y0, logic [7:0] y1);
    line_cmd_t cmd;
    cmd = '{func: func, x0: x0, x1: x1, y0: y0, y1: y1};
    pending_cmds.push_back(cmd);
  endtask

  // A start followed by a number of steps with random, ignored coordinates.
  task automatic queue_line(logic [7:0] x0, logic [7:0] x1, logic [7:0] y0,
                            logic [7:0] y1, int unsigned steps);
    push_cmd(blps_pkg::FUNC_START, x0, x1, y0, y1);
    repeat (steps)
      push_cmd(blps_pkg::FUNC_STEP, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // A random line: mostly short and complete, some long, abandoned or overrun.
  task automatic queue_random_line(output int unsigned counted);
    logic [7:0] x0;
    logic [7:0] x1;
    logic [7:0] y0;
    logic [7:0] y1;
    logic [7:0] xd;
    logic [7:0] yd;
    int unsigned pixels;
    int unsigned steps;
    int unsigned r;
    x0 = 8'($urandom_range(0, 255));
    y0 = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 4) begin
      x1 = 8'($urandom_range(0, 255));
      y1 = 8'($urandom_range(0, 255));
    end else if (r < 8) begin
      x1 = x0;
      y1 = y0;
    end else begin
      x1 = x0 + 8'($urandom_range(0, 24)) - 8'd12;
      y1 = y0 + 8'($urandom_range(0, 24)) - 8'd12;
    end
    xd = (x0 < x1) ? x1 - x0 : x0 - x1;
    yd = (y0 < y1) ? y1 - y0 : y0 - y1;
    pixels = (xd > yd) ? 32'(xd) : 32'(yd);
    r = $urandom_range(0, 99);
    if (r < 75) steps = pixels;
    else if (r < 88) steps = $urandom_range(0, pixels);
    else steps = pixels + $urandom_range(1, 3);
    queue_line(x0, x1, y0, y1, steps);
    counted = 1 + ((steps < pixels) ? steps : pixels);
  endtask

  // Wait until every command is sent and every pixel has arrived.
  task automatic drain();
    while (pending_cmds.size() != 0 || pending_pixels.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_page(logic [7:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    page_shadow = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stimulus: reset, directed lines, then random phases with page changes.
  initial begin
    int unsigned counted;
    int unsigned n;
    logic [7:0] page;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.func = blps_pkg::FUNC_STEP;
    in_ch.start_x = '0;
    in_ch.end_x = '0;
    in_ch.start_y = '0;
    in_ch.end_y = '0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_page(8'h00);
    // A step with no line in progress, then a single-point line and a stray step.
    push_cmd(blps_pkg::FUNC_STEP, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_line(8'h00, 8'h00, 8'h00, 8'h00, 1);
    // Shallow line given right to left, drawn from its left end with the minor axis counting down.
    queue_line(8'hFF, 8'hFA, 8'h00, 8'h03, 5);
    // Equal extents pick y as the major axis.
    queue_line(8'h00, 8'h04, 8'h04, 8'h00, 4);
    // Steep line at the far corner, abandoned by a full-screen diagonal.
    queue_line(8'hFF, 8'hFE, 8'hFA, 8'hFF, 3);
    queue_line(8'h00, 8'hFF, 8'hFF, 8'h00, 2);
    // Short line across a character row, with one step too many.
    queue_line(8'h80, 8'h80, 8'h07, 8'h08, 2);
    drain();

    for (int p = 1; p < PHASES; p++) begin
      case (p)
        1: page = 8'hFF;
        2: page = 8'h01;
        4: page = 8'h80;
        default: page = 8'($urandom_range(0, 255));
      endcase
      write_page(page);
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        queue_random_line(counted);
        n += counted;
        // Hold the sender once mid-phase until the block has emptied.
        if (p == 3 && n >= ITEMS_PER_PHASE / 2 && n - counted < ITEMS_PER_PHASE / 2)
          drain();
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (errors == 0 && pending_pixels.size() == 0)
      $display("bitmap_line_pixel_stepper verification clean");
    else
      $display("bitmap_line_pixel_stepper verification failed");
    $finish;
  end

endmodule
